### hw/rtl/hgc_pkg.sv
// Package for the coupled hardcore-model Glauber step block.
// Holds the item, result, configuration and command types, and fixed widths.
// No dependencies; used by hgc_ctrl, hgc_datapath and the top level.
package hgc_pkg;

  // Field widths of the items and registers.
  localparam int unsigned ROW_W    = 6;
  localparam int unsigned COL_W    = 6;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned SIDE_W   = 7;
  localparam int unsigned THRESH_W = 33;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned STEP_W   = 48;

  // Request codes carried in req_type.
  localparam logic REQ_RESTART = 1'b0;
  localparam logic REQ_UPDATE  = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd1;

  // Register values after reset.
  localparam logic [SIDE_W-1:0]   SIDE_RESET   = 7'd64;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 33'h0_8000_0000;

  // One input item.
  typedef struct packed {
    logic              req_type;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [WORD_W-1:0] random_word;
  } hgc_in_t;

  // One result item.
  typedef struct packed {
    logic [COUNT_W-1:0] diff_count;
    logic               coupled;
    logic [STEP_W-1:0]  step_count;
    logic               bad_coordinate;
  } hgc_out_t;

  // Configuration register contents.
  typedef struct packed {
    logic [SIDE_W-1:0]   side;
    logic [THRESH_W-1:0] occupy_threshold;
  } hgc_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;      // item accepted: latch it, read the rows above and below
    logic read_center;  // read the row of the chosen cell
    logic execute;      // apply restart or update to grids and counters
    logic emit;         // load the result register
  } hgc_cmd_t;

endpackage

### hw/rtl/hgc_ctrl.sv
// Controller state machine of the coupled Glauber step block.
// Sequences capture, row reads, execution and result hand-off; owns out valid.
// Depends on hgc_pkg for the command struct.
module hgc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hgc_pkg::hgc_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The result register is free when empty or being taken this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read_center = 1'b1;
        state_d           = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result valid is set on emit and cleared when the item is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/hgc_datapath.sv
// Datapath of the coupled Glauber step block: row memory of both chains,
// row valid flags, neighbor logic, difference and step counters, result register.
// Depends on hgc_pkg for item, result, configuration and command types.
module hgc_datapath #(
  parameter int unsigned MAX_SIDE = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hgc_pkg::hgc_cmd_t cmd_i,
  input  hgc_pkg::hgc_cfg_t cfg_i,
  input  hgc_pkg::hgc_in_t  in_data_i,
  output hgc_pkg::hgc_out_t out_data_o
);

  localparam int unsigned SW      = hgc_pkg::SIDE_W;
  localparam int unsigned CNT_W   = hgc_pkg::COUNT_W;
  localparam int unsigned STP_W   = hgc_pkg::STEP_W;
  localparam int unsigned RW      = $clog2(MAX_SIDE);
  localparam int unsigned DEPTH   = 1 << RW;
  localparam int unsigned WORD_W  = 2 * MAX_SIDE;
  localparam int unsigned SAT_W   = $clog2(MAX_SIDE + 1);
  localparam int unsigned CW      = (SW > SAT_W) ? SW : SAT_W;
  localparam int unsigned DEF_SIDE = int'(hgc_pkg::SIDE_RESET);
  localparam int unsigned RST_SIDE = (MAX_SIDE < DEF_SIDE) ? MAX_SIDE : DEF_SIDE;
  localparam logic [CNT_W-1:0] RST_DIFF =
    CNT_W'((RST_SIDE * RST_SIDE) % (1 << CNT_W));

  // Side in use, saturated at the grid size.
  logic [CW-1:0] side_ext;
  logic [CW-1:0] side_sat;
  logic [SW-1:0] side_use;

  assign side_ext = CW'(cfg_i.side);
  assign side_sat = (side_ext > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : side_ext;
  assign side_use = SW'(side_sat);

  // Row neighbors and coordinate check for the incoming item.
  logic [SW-1:0] row_in;
  logic [SW-1:0] col_in;
  logic [SW-1:0] up_in;
  logic [SW-1:0] dn_in;
  logic          bad_in;

  always_comb begin
    row_in = SW'(in_data_i.row);
    col_in = SW'(in_data_i.col);
    dn_in  = (row_in + SW'(1) == side_use) ? '0 : row_in + SW'(1);
    up_in  = (row_in == '0) ? side_use - SW'(1) : row_in - SW'(1);
    bad_in = (in_data_i.req_type == hgc_pkg::REQ_UPDATE) &&
             ((row_in >= side_use) || (col_in >= side_use));
  end

  // Latched item.
  logic                        req_q;
  logic [hgc_pkg::ROW_W-1:0]   row_q;
  logic [hgc_pkg::COL_W-1:0]   col_q;
  logic [hgc_pkg::WORD_W-1:0]  word_q;
  logic                        bad_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= in_data_i.req_type;
      row_q  <= in_data_i.row;
      col_q  <= in_data_i.col;
      word_q <= in_data_i.random_word;
      bad_q  <= bad_in;
    end
  end

  // Column neighbors of the latched cell.
  logic [SW-1:0] col_ext;
  logic [SW-1:0] col_rt;
  logic [SW-1:0] col_lf;
  logic [RW-1:0] col_idx;
  logic [RW-1:0] rt_idx;
  logic [RW-1:0] lf_idx;
  logic [RW-1:0] ctr_addr;

  always_comb begin
    col_ext  = SW'(col_q);
    col_rt   = (col_ext + SW'(1) == side_use) ? '0 : col_ext + SW'(1);
    col_lf   = (col_ext == '0) ? side_use - SW'(1) : col_ext - SW'(1);
    col_idx  = RW'(col_q);
    rt_idx   = RW'(col_rt);
    lf_idx   = RW'(col_lf);
    ctr_addr = RW'(row_q);
  end

  // Row memory: each word holds one row of chain Y (upper) and chain X (lower).
  // A row whose valid flag is clear reads as the start checkerboard.
  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]  row_vld_q;
  logic [WORD_W-1:0] rd_a_q;
  logic [WORD_W-1:0] rd_b_q;
  logic              vld_a_q;
  logic              vld_b_q;
  logic              par_a_q;
  logic              par_b_q;
  logic [RW-1:0]     rd_a_addr;
  logic              rd_a_par;
  logic              rd_a_en;
  logic              wr_en;
  logic [WORD_W-1:0] wr_word;

  assign rd_a_en   = cmd_i.capture || cmd_i.read_center;
  assign rd_a_addr = cmd_i.capture ? RW'(up_in) : ctr_addr;
  assign rd_a_par  = cmd_i.capture ? up_in[0] : row_q[0];
  assign wr_en     = cmd_i.execute && (req_q == hgc_pkg::REQ_UPDATE) && !bad_q;

  always_ff @(posedge clk_i) begin
    if (rd_a_en) begin
      rd_a_q  <= mem_q[rd_a_addr];
      vld_a_q <= row_vld_q[rd_a_addr];
      par_a_q <= rd_a_par;
    end
    if (cmd_i.capture) begin
      rd_b_q  <= mem_q[RW'(dn_in)];
      vld_b_q <= row_vld_q[RW'(dn_in)];
      par_b_q <= dn_in[0];
    end
    if (wr_en) begin
      mem_q[ctr_addr] <= wr_word;
    end
  end

  // Start pattern: chain X holds cells of even row plus column.
  logic [MAX_SIDE-1:0] even_x;
  logic [WORD_W-1:0]   def_even;
  logic [WORD_W-1:0]   def_odd;
  logic [WORD_W-1:0]   eff_a;
  logic [WORD_W-1:0]   eff_b;

  always_comb begin
    for (int i = 0; i < MAX_SIDE; i++) begin
      even_x[i] = ((i & 1) == 0);
    end
    def_even = {~even_x, even_x};
    def_odd  = {even_x, ~even_x};
    eff_a    = vld_a_q ? rd_a_q : (par_a_q ? def_odd : def_even);
    eff_b    = vld_b_q ? rd_b_q : (par_b_q ? def_odd : def_even);
  end

  // Occupancy of the rows above and below in the chosen column.
  logic [MAX_SIDE-1:0] ax;
  logic [MAX_SIDE-1:0] ay;
  logic [MAX_SIDE-1:0] bx;
  logic [MAX_SIDE-1:0] by;
  logic                nbx_q;
  logic                nby_q;

  assign ax = eff_a[MAX_SIDE-1:0];
  assign ay = eff_a[WORD_W-1:MAX_SIDE];
  assign bx = eff_b[MAX_SIDE-1:0];
  assign by = eff_b[WORD_W-1:MAX_SIDE];

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_center) begin
      nbx_q <= ax[col_idx] | bx[col_idx];
      nby_q <= ay[col_idx] | by[col_idx];
    end
  end

  // Heat-bath move of both chains on the center row read last.
  logic                occupy;
  logic                x_old;
  logic                y_old;
  logic                x_new;
  logic                y_new;
  logic                was_same;
  logic                now_same;
  logic [MAX_SIDE-1:0] new_x;
  logic [MAX_SIDE-1:0] new_y;

  always_comb begin
    occupy = ({1'b0, word_q} <= cfg_i.occupy_threshold);
    x_old  = ax[col_idx];
    y_old  = ay[col_idx];
    x_new  = occupy ? (x_old | ~(nbx_q | ax[lf_idx] | ax[rt_idx])) : 1'b0;
    y_new  = occupy ? (y_old | ~(nby_q | ay[lf_idx] | ay[rt_idx])) : 1'b0;
    was_same = (x_old == y_old);
    now_same = (x_new == y_new);
    new_x    = ax;
    new_y    = ay;
    new_x[col_idx] = x_new;
    new_y[col_idx] = y_new;
    wr_word  = {new_y, new_x};
  end

  // Restart count is the side in use squared, kept to the count width.
  logic [2*SW-1:0] side_sq;

  assign side_sq = (2 * SW)'(side_use) * (2 * SW)'(side_use);

  // Row valid flags and counters.
  logic [CNT_W-1:0] diff_q;
  logic [STP_W-1:0] steps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      diff_q    <= RST_DIFF;
      steps_q   <= '0;
    end else if (cmd_i.execute) begin
      if (req_q == hgc_pkg::REQ_RESTART) begin
        row_vld_q <= '0;
        diff_q    <= CNT_W'(side_sq);
        steps_q   <= '0;
      end else if (!bad_q) begin
        row_vld_q[ctr_addr] <= 1'b1;
        steps_q             <= steps_q + STP_W'(1);
        if (was_same && !now_same) begin
          diff_q <= diff_q + CNT_W'(1);
        end else if (!was_same && now_same) begin
          diff_q <= diff_q - CNT_W'(1);
        end
      end
    end
  end

  // Result register.
  hgc_pkg::hgc_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.diff_count     <= diff_q;
      out_q.coupled        <= (diff_q == '0);
      out_q.step_count     <= steps_q;
      out_q.bad_coordinate <= bad_q;
    end
  end

  assign out_data_o = out_q;

endmodule

### hw/rtl/hardcore_glauber_coupling_step.sv
// Top level of the coupled hardcore-model Glauber step block.
// Holds the configuration registers; instantiates hgc_ctrl and hgc_datapath.
// Depends on hgc_pkg.
//
//   Channel   Direction  Handshake               Payload
//   in        input      in_valid_i / in_stall_o  hgc_in_t   (req_type, row, col, word)
//   out       output     out_valid_o/out_stall_i  hgc_out_t  (diff, coupled, steps, bad)
//   cfg       input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// Every item, restart or update, passes in turn through accept with the reads of the
// rows above and below, read of the center row, execution, result hand-off.
// The single row memory has two read ports and one write port.
// Reset clears the per-row valid flags, so all rows read as the start pattern at
// once; there is no clearing pass. A stalled result waits in the result register
// while the next item is accepted; that item holds before hand-off until it is free.
module hardcore_glauber_coupling_step #(
  parameter int unsigned MAX_SIDE = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  hgc_pkg::hgc_in_t                      in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output hgc_pkg::hgc_out_t                     out_data_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [hgc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [hgc_pkg::THRESH_W-1:0]          cfg_data_i
);

  hgc_pkg::hgc_cmd_t cmd;
  hgc_pkg::hgc_cfg_t cfg;

  logic [hgc_pkg::SIDE_W-1:0]   side_q;
  logic [hgc_pkg::THRESH_W-1:0] thresh_q;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q   <= hgc_pkg::SIDE_RESET;
      thresh_q <= hgc_pkg::THRESH_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hgc_pkg::CFG_SIDE: begin
          side_q <= cfg_data_i[hgc_pkg::SIDE_W-1:0];
        end
        hgc_pkg::CFG_THRESH: begin
          thresh_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.side             = side_q;
  assign cfg.occupy_threshold = thresh_q;

  // Sequencer.
  hgc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Grids, counters and result register.
  hgc_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule
